// File: hdl/cbfd_pkg.sv
// Shared widths and step counts for the bead force direction pipeline.
package cbfd_pkg;
  localparam int T_W        = 31;
  localparam int N2_W       = 64;
  localparam int LEN_W      = 32;
  localparam int NUM_W      = 62;
  localparam int U_W        = 31;
  localparam int ROUND_SHIFT = 30;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  localparam int MUL_LAT    = 2;

  typedef logic [T_W-1:0]   mant_t;
  typedef logic [N2_W-1:0]  norm2_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [NUM_W-1:0] num_t;
  typedef logic [U_W-1:0]   unit_t;
endpackage

// File: hdl/cbfd_mul.sv
// Two-stage signed multiplier built from four half-width partial products.
module cbfd_mul #(
  parameter int WA = 33,
  parameter int WB = 33
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [WA-1:0]  a,
  input  logic signed [WB-1:0]  b,
  output logic signed [WA+WB-1:0] p
);
  localparam int LA = WA / 2;
  localparam int LB = WB / 2;
  localparam int HA = WA - LA;
  localparam int HB = WB - LB;
  localparam int PW = WA + WB;

  logic signed [HA-1:0] ah;
  logic signed [HB-1:0] bh;
  logic [LA-1:0] al;
  logic [LB-1:0] bl;

  logic signed [HA+HB-1:0] pp_hh;
  logic signed [HA+LB:0]   pp_hl;
  logic signed [LA+HB:0]   pp_lh;
  logic [LA+LB-1:0]        pp_ll;

  logic signed [PW-1:0] e_hh, e_hl, e_lh, e_ll;

  assign ah = a[WA-1:LA];
  assign al = a[LA-1:0];
  assign bh = b[WB-1:LB];
  assign bl = b[LB-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= ah * bh;
      pp_hl <= ah * $signed({1'b0, bl});
      pp_lh <= $signed({1'b0, al}) * bh;
      pp_ll <= al * bl;
    end
  end

  always_comb begin
    e_hh = PW'(pp_hh);
    e_hl = PW'(pp_hl);
    e_lh = PW'(pp_lh);
    e_ll = $signed(PW'(pp_ll));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= (e_hh <<< (LA + LB)) + (e_hl <<< LA) + (e_lh <<< LB) + e_ll;
    end
  end
endmodule

// File: hdl/cbfd_delay.sv
// Enabled shift line that keeps side data in step with the pipeline.
module cbfd_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] line [D];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < D; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[D-1];
endmodule

// File: hdl/cbfd_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module cbfd_sqrt (
  input  logic             clk,
  input  logic             en,
  input  cbfd_pkg::norm2_t n,
  output cbfd_pkg::len_t   root
);
  import cbfd_pkg::*;

  logic [N2_W-1:0] rem_in [SQRT_STEPS];
  logic [N2_W-1:0] res_in [SQRT_STEPS];
  logic [N2_W-1:0] rem_q  [SQRT_STEPS];
  logic [N2_W-1:0] res_q  [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [N2_W-1:0] BIT = N2_W'(1) << (N2_W - 2 - 2 * i);
    logic [N2_W-1:0] trial;

    if (i == 0) begin : g_first
      assign rem_in[i] = n;
      assign res_in[i] = '0;
    end else begin : g_next
      assign rem_in[i] = rem_q[i-1];
      assign res_in[i] = res_q[i-1];
    end

    assign trial = res_in[i] + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in[i] >= trial) begin
          rem_q[i] <= rem_in[i] - trial;
          res_q[i] <= (res_in[i] >> 1) + BIT;
        end else begin
          rem_q[i] <= rem_in[i];
          res_q[i] <= res_in[i] >> 1;
        end
      end
    end
  end

  assign root = res_q[SQRT_STEPS-1][LEN_W-1:0];
endmodule

// File: hdl/cbfd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module cbfd_div (
  input  logic           clk,
  input  logic           en,
  input  cbfd_pkg::num_t num,
  input  cbfd_pkg::len_t den,
  output cbfd_pkg::unit_t quo
);
  import cbfd_pkg::*;

  logic [NUM_W-1:0] rem_in [DIV_STEPS];
  logic [LEN_W-1:0] den_in [DIV_STEPS];
  logic [U_W-1:0]   quo_in [DIV_STEPS];
  logic [NUM_W-1:0] rem_q  [DIV_STEPS];
  logic [LEN_W-1:0] den_q  [DIV_STEPS];
  logic [U_W-1:0]   quo_q  [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    localparam int POS = DIV_STEPS - 1 - j;
    logic [NUM_W:0] cand;

    if (j == 0) begin : g_first
      assign rem_in[j] = num;
      assign den_in[j] = den;
      assign quo_in[j] = '0;
    end else begin : g_next
      assign rem_in[j] = rem_q[j-1];
      assign den_in[j] = den_q[j-1];
      assign quo_in[j] = quo_q[j-1];
    end

    assign cand = (NUM_W + 1)'(den_in[j]) << POS;

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[j] <= den_in[j];
        if ({1'b0, rem_in[j]} >= cand) begin
          rem_q[j] <= rem_in[j] - cand[NUM_W-1:0];
          quo_q[j] <= quo_in[j] | (U_W'(1) << POS);
        end else begin
          rem_q[j] <= rem_in[j];
          quo_q[j] <= quo_in[j];
        end
      end
    end
  end

  assign quo = quo_q[DIV_STEPS-1];
endmodule

// File: hdl/chain_bead_force_direction.sv
// Top level of the bead force direction pipeline.
// Throughput: one transaction per cycle; the whole pipeline holds when the output stalls.
// The depth is set by the 32-step square root and the 31-step divider.
// Reset clears the stage valid bits only; data registers are not reset.
module chain_bead_force_direction #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] point_a_x,
  input  logic signed [COORD_WIDTH-1:0] point_a_y,
  input  logic signed [COORD_WIDTH-1:0] point_a_z,
  input  logic signed [COORD_WIDTH-1:0] point_b_x,
  input  logic signed [COORD_WIDTH-1:0] point_b_y,
  input  logic signed [COORD_WIDTH-1:0] point_b_z,
  input  logic signed [COORD_WIDTH-1:0] point_c_x,
  input  logic signed [COORD_WIDTH-1:0] point_c_y,
  input  logic signed [COORD_WIDTH-1:0] point_c_z,
  input  logic signed [COORD_WIDTH-1:0] magnitude,
  input  logic                          turn_negative,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] force_x,
  output logic signed [COORD_WIDTH-1:0] force_y,
  output logic signed [COORD_WIDTH-1:0] force_z,
  output logic                          degenerate
);
  import cbfd_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int RW  = CW + 1;
  localparam int PW  = 2 * RW;
  localparam int XW  = 2 * CW + 3;
  localparam int DW  = 2 * CW + 5;
  localparam int QW  = DW + RW;
  localparam int SW  = QW + 1;
  localparam int LZW = $clog2(SW + 1);
  localparam int MW  = U_W + 1 + RW;
  localparam int FW  = CW + 3;
  localparam int LAT = 80;
  localparam logic [FW-1:0] MAXPOS = FW'({1'b0, {(CW - 1){1'b1}}});
  localparam logic [MW-1:0] HALF = MW'(1) << (ROUND_SHIFT - 1);

  logic adv;
  logic vld [LAT];

  logic signed [RW-1:0] r1 [3];
  logic signed [RW-1:0] r2 [3];
  logic signed [RW-1:0] r1_d [3];
  logic [CW-1:0] mmag;
  logic mag_neg, mnz, turn;

  logic signed [PW-1:0] pd [3];
  logic signed [PW-1:0] pc1 [3];
  logic signed [PW-1:0] pc2 [3];
  logic signed [DW-1:0] p2;
  logic signed [XW-1:0] cr [3];
  logic signed [XW-1:0] cr_d [3];
  logic signed [QW-1:0] par [3];
  logic turn_d, mag_neg_d;
  logic signed [SW-1:0] s [3];
  logic [SW-1:0] ms [3];
  logic [SW-1:0] ms9 [3];
  logic xs [3];
  logic [SW-1:0] orv;
  logic [LZW-1:0] lz, lz_next;
  logic deg9;
  mant_t t [3];
  mant_t t_d [3];
  logic [2*T_W-1:0] sq [3];
  norm2_t n2;
  len_t len;
  num_t num [3];
  len_t den;
  unit_t u [3];
  logic [CW-1:0] mmag_d;
  logic mnz_d;
  logic xs_d [3];
  logic neg76 [3];
  logic neg79 [3];
  logic signed [MW-1:0] prod [3];
  logic [FW-1:0] f [3];
  logic deg79;
  logic signed [CW-1:0] frc [3];

  assign adv       = !vld[LAT-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < LAT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1[0] <= RW'(point_b_x) - RW'(point_a_x);
      r1[1] <= RW'(point_b_y) - RW'(point_a_y);
      r1[2] <= RW'(point_b_z) - RW'(point_a_z);
      r2[0] <= RW'(point_c_x) - RW'(point_b_x);
      r2[1] <= RW'(point_c_y) - RW'(point_b_y);
      r2[2] <= RW'(point_c_z) - RW'(point_b_z);
      mmag    <= magnitude[CW-1] ? CW'(0) - magnitude : magnitude;
      mag_neg <= magnitude[CW-1];
      mnz     <= magnitude != '0;
      turn    <= turn_negative;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_vec
    localparam int I1 = (k + 1) % 3;
    localparam int I2 = (k + 2) % 3;

    cbfd_mul #(.WA(RW), .WB(RW)) u_dot (
      .clk(clk), .en(adv), .a(r1[k]), .b(r2[k]), .p(pd[k])
    );
    cbfd_mul #(.WA(RW), .WB(RW)) u_cr1 (
      .clk(clk), .en(adv), .a(r1[I1]), .b(r2[I2]), .p(pc1[k])
    );
    cbfd_mul #(.WA(RW), .WB(RW)) u_cr2 (
      .clk(clk), .en(adv), .a(r1[I2]), .b(r2[I1]), .p(pc2[k])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        cr[k] <= XW'(pc1[k]) - XW'(pc2[k]);
      end
    end

    cbfd_delay #(.W(RW), .D(3)) u_r1_d (
      .clk(clk), .en(adv), .d(r1[k]), .q(r1_d[k])
    );
    cbfd_mul #(.WA(DW), .WB(RW)) u_par (
      .clk(clk), .en(adv), .a(p2), .b(r1_d[k]), .p(par[k])
    );
    cbfd_delay #(.W(XW), .D(2)) u_cr_d (
      .clk(clk), .en(adv), .d(cr[k]), .q(cr_d[k])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        s[k]   <= turn_d ? SW'(par[k]) - SW'(cr_d[k]) : SW'(par[k]) + SW'(cr_d[k]);
        ms[k]  <= s[k][SW-1] ? SW'(0) - s[k] : s[k];
        xs[k]  <= s[k][SW-1] ^ mag_neg_d;
        ms9[k] <= ms[k];
        t[k]   <= mant_t'((ms9[k] << lz) >> (SW - T_W));
        sq[k]  <= t[k] * t[k];
      end
    end

    cbfd_delay #(.W(T_W), .D(34)) u_t_d (
      .clk(clk), .en(adv), .d(t[k]), .q(t_d[k])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        num[k] <= {t_d[k], ROUND_SHIFT'(0)} + NUM_W'(len >> 1);
      end
    end

    cbfd_div u_div (
      .clk(clk), .en(adv), .num(num[k]), .den(den), .quo(u[k])
    );

    cbfd_delay #(.W(1), .D(68)) u_xs_d (
      .clk(clk), .en(adv), .d(xs[k]), .q(xs_d[k])
    );

    assign neg76[k] = xs_d[k] && (u[k] != '0) && mnz_d;

    cbfd_delay #(.W(1), .D(3)) u_neg_d (
      .clk(clk), .en(adv), .d(neg76[k]), .q(neg79[k])
    );

    cbfd_mul #(.WA(U_W + 1), .WB(RW)) u_scale (
      .clk(clk), .en(adv), .a($signed({1'b0, u[k]})), .b($signed({1'b0, mmag_d})),
      .p(prod[k])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        f[k] <= FW'((prod[k] + HALF) >> ROUND_SHIFT);
        if (neg79[k]) begin
          frc[k] <= (f[k] > MAXPOS) ? {1'b1, {(CW - 1){1'b0}}} : CW'(0) - f[k][CW-1:0];
        end else begin
          frc[k] <= (f[k] > MAXPOS) ? MAXPOS[CW-1:0] : f[k][CW-1:0];
        end
      end
    end
  end

  cbfd_delay #(.W(1), .D(5)) u_turn_d (
    .clk(clk), .en(adv), .d(turn), .q(turn_d)
  );
  cbfd_delay #(.W(1), .D(6)) u_mneg_d (
    .clk(clk), .en(adv), .d(mag_neg), .q(mag_neg_d)
  );
  cbfd_delay #(.W(CW), .D(75)) u_mmag_d (
    .clk(clk), .en(adv), .d(mmag), .q(mmag_d)
  );
  cbfd_delay #(.W(1), .D(75)) u_mnz_d (
    .clk(clk), .en(adv), .d(mnz), .q(mnz_d)
  );
  cbfd_delay #(.W(1), .D(70)) u_deg_d (
    .clk(clk), .en(adv), .d(deg9), .q(deg79)
  );

  assign orv = ms[0] | ms[1] | ms[2];

  always_comb begin
    lz_next = LZW'(SW);
    for (int i = 0; i < SW; i++) begin
      if (orv[i]) begin
        lz_next = LZW'(SW - 1 - i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2   <= (DW'(pd[0]) + DW'(pd[1]) + DW'(pd[2])) <<< 1;
      lz   <= lz_next;
      deg9 <= orv == '0;
      n2   <= N2_W'(sq[0]) + N2_W'(sq[1]) + N2_W'(sq[2]);
      den  <= (len == '0) ? LEN_W'(1) : len;
      degenerate <= deg79;
    end
  end

  cbfd_sqrt u_sqrt (
    .clk(clk), .en(adv), .n(n2), .root(len)
  );

  assign force_x = frc[0];
  assign force_y = frc[1];
  assign force_z = frc[2];

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> force_x == '0 && force_y == '0 && force_z == '0)
    else $error("degenerate result with nonzero force");

  a_valid_chain: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vld[LAT-2]))
    else $error("output valid without a preceding stage");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld[0]) && $stable(n2))
    else $error("pipeline moved during a stall");
endmodule
